// ----- rtl/core/topk_pkg.sv -----
package topk_pkg;

  // Width and reset value of the select_count register.
  localparam int SEL_BITS = 5;
  localparam logic [SEL_BITS-1:0] SEL_RESET = 5'd16;

  // Per-cycle control that the top level hands to every cell of the row.
  typedef struct packed {
    logic insert;  // an input item is accepted this cycle
    logic drain;   // the head entry is taken by the result channel this cycle
  } topk_ctl_t;

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } topk_state_t;

endpackage

// ----- rtl/core/topk_in_if.sv -----
interface topk_in_if #(
  parameter int KEY_BITS   = 32,
  parameter int INDEX_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [KEY_BITS-1:0]   key;
  logic        [INDEX_BITS-1:0] item_index;
  logic                         set_end;

  modport source (output valid, key, item_index, set_end, input ready);
  modport sink   (input valid, key, item_index, set_end, output ready);
endinterface

// ----- rtl/core/topk_out_if.sv -----
interface topk_out_if #(
  parameter int KEY_BITS   = 32,
  parameter int INDEX_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic        [INDEX_BITS-1:0] out_index;
  logic signed [KEY_BITS-1:0]   out_key;
  logic                         out_last;

  modport source (output valid, out_index, out_key, out_last, input ready);
  modport sink   (input valid, out_index, out_key, out_last, output ready);
endinterface

// ----- rtl/core/topk_cfg_if.sv -----
interface topk_cfg_if;
  import topk_pkg::*;

  logic                valid;
  logic                ready;
  logic [SEL_BITS-1:0] select_count;

  modport source (output valid, select_count, input ready);
  modport sink   (input valid, select_count, output ready);
endinterface

// ----- rtl/core/topk_cell.sv -----
// One slot of the sorted list. On an insert the slot keeps its entry, takes
// the new item, takes its upper neighbor's entry or, above the capacity, empties;
// on a drain it takes its lower neighbor's entry so the list moves toward the head.
module topk_cell
  import topk_pkg::*;
#(
  parameter int KEY_BITS   = 32,
  parameter int INDEX_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  topk_ctl_t             ctl,
  input  logic                  en,          // slot lies below the current capacity
  input  logic [KEY_BITS-1:0]   in_key,
  input  logic [KEY_BITS-1:0]   in_mag,
  input  logic [INDEX_BITS-1:0] in_id,
  input  logic                  prev_ahead,
  input  logic                  prev_vld,
  input  logic [KEY_BITS-1:0]   prev_key,
  input  logic [KEY_BITS-1:0]   prev_mag,
  input  logic [INDEX_BITS-1:0] prev_id,
  input  logic                  next_vld,
  input  logic [KEY_BITS-1:0]   next_key,
  input  logic [KEY_BITS-1:0]   next_mag,
  input  logic [INDEX_BITS-1:0] next_id,
  output logic                  vld,
  output logic                  ahead,
  output logic [KEY_BITS-1:0]   key,
  output logic [KEY_BITS-1:0]   mag,
  output logic [INDEX_BITS-1:0] id
);

  logic                  valid_r, valid_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [KEY_BITS-1:0]   mag_r, mag_nxt;
  logic [INDEX_BITS-1:0] id_r, id_nxt;

  // An entry above the capacity counts as dropped.
  assign vld   = valid_r & en;
  // Equal magnitudes stay ahead of the newcomer, which keeps arrival order.
  assign ahead = vld & (mag_r >= in_mag);
  assign key   = key_r;
  assign mag   = mag_r;
  assign id    = id_r;

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    mag_nxt   = mag_r;
    id_nxt    = id_r;
    if (ctl.insert) begin
      if (!en) begin
        valid_nxt = 1'b0;
      end else if (ahead) begin
        valid_nxt = 1'b1;
      end else if (prev_ahead) begin
        valid_nxt = 1'b1;
        key_nxt   = in_key;
        mag_nxt   = in_mag;
        id_nxt    = in_id;
      end else begin
        valid_nxt = prev_vld;
        key_nxt   = prev_key;
        mag_nxt   = prev_mag;
        id_nxt    = prev_id;
      end
    end else if (ctl.drain) begin
      valid_nxt = next_vld;
      key_nxt   = next_key;
      mag_nxt   = next_mag;
      id_nxt    = next_id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    mag_r <= mag_nxt;
    id_r  <= id_nxt;
  end

endmodule

// ----- rtl/core/topk_magnitude_select.sv -----
// Streaming top-k selection by key magnitude. Items of a set arrive on in_ch
// and are kept in a row of MAX_SELECT compare-and-shift cells, sorted by the
// absolute value of the key with the largest first; among equal magnitudes
// the earlier item stays ahead. The most negative key ranks above all others.
// While the list holds fewer than select_count entries every item is
// inserted; once it is full an item enters only when its magnitude beats the
// smallest kept entry, which then falls off the end. Each item is inserted in
// the cycle it is accepted, so a set streams in at one item per cycle. The
// item that carries set_end is inserted as well, after which in_ch.ready
// drops and the kept entries leave on out_ch, largest first, one per
// accepted result, with out_last on the final one; the row shifts toward its
// head on every result taken. The list is empty again when the last result is
// taken. select_count of zero acts as one and values above MAX_SELECT act as
// MAX_SELECT; it is written on cfg_ch, which is always ready, and should only
// change between sets or while no item is in flight. Lowering it inside a set
// drops the entries above the new capacity.
module topk_magnitude_select
  import topk_pkg::*;
#(
  parameter int MAX_SELECT = 16,
  parameter int KEY_BITS   = 32,
  parameter int INDEX_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  topk_in_if.sink    in_ch,
  topk_out_if.source out_ch,
  topk_cfg_if.sink   cfg_ch
);

  localparam int CAP_W = $clog2(MAX_SELECT + 1);

  // Capacity register and the capacity it stands for.
  logic [SEL_BITS-1:0] sel_r, sel_nxt;
  logic [CAP_W-1:0]    cap;

  topk_state_t state_r, state_nxt;
  topk_ctl_t   ctl;

  logic                in_acc, out_acc;
  logic [KEY_BITS-1:0] in_mag;

  // Cell row. The valid vector has one spare slot past the end that is
  // always empty; the tail cell drains an empty entry as well.
  logic [MAX_SELECT-1:0] cell_en;
  logic [MAX_SELECT-1:0] cell_ahead;
  logic [MAX_SELECT:0]   cell_vld;
  logic [KEY_BITS-1:0]   cell_key [MAX_SELECT];
  logic [KEY_BITS-1:0]   cell_mag [MAX_SELECT];
  logic [INDEX_BITS-1:0] cell_id  [MAX_SELECT];

  assign cfg_ch.ready = 1'b1;
  assign sel_nxt      = (cfg_ch.valid && cfg_ch.ready) ? cfg_ch.select_count : sel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= SEL_RESET;
    end else begin
      sel_r <= sel_nxt;
    end
  end

  always_comb begin
    if (sel_r == '0) begin
      cap = CAP_W'(1);
    end else if (int'(sel_r) > MAX_SELECT) begin
      cap = CAP_W'(MAX_SELECT);
    end else begin
      cap = CAP_W'(sel_r);
    end
    for (int i = 0; i < MAX_SELECT; i++) begin
      cell_en[i] = CAP_W'(i) < cap;
    end
  end

  // Magnitude as an unsigned value of the key's width; the most negative
  // key maps to 2^(KEY_BITS-1) without saturating.
  assign in_mag = in_ch.key[KEY_BITS-1] ? (~in_ch.key + KEY_BITS'(1)) : in_ch.key;

  assign in_ch.ready = (state_r == ST_FILL);
  assign in_acc      = in_ch.valid & in_ch.ready;
  assign out_acc     = out_ch.valid & out_ch.ready;
  assign ctl         = '{insert: in_acc, drain: out_acc};

  // The head cell is the output register of the block.
  assign out_ch.valid     = (state_r == ST_DRAIN) & cell_vld[0];
  assign out_ch.out_index = cell_id[0];
  assign out_ch.out_key   = cell_key[0];
  assign out_ch.out_last  = ~cell_vld[1];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_FILL: begin
        if (in_acc && in_ch.set_end) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_acc && out_ch.out_last) begin
          state_nxt = ST_FILL;
        end
      end
      default: state_nxt = ST_FILL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FILL;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign cell_vld[MAX_SELECT] = 1'b0;

  for (genvar i = 0; i < MAX_SELECT; i++) begin : g_cell
    logic                  prev_ahead, prev_vld, next_vld;
    logic [KEY_BITS-1:0]   prev_key, prev_mag, next_key, next_mag;
    logic [INDEX_BITS-1:0] prev_id, next_id;

    if (i == 0) begin : g_head
      // Nothing stands ahead of the head, so a newcomer that loses to no
      // kept entry lands here.
      assign prev_ahead = 1'b1;
      assign prev_vld   = 1'b0;
      assign prev_key   = in_ch.key;
      assign prev_mag   = in_mag;
      assign prev_id    = in_ch.item_index;
    end else begin : g_body
      assign prev_ahead = cell_ahead[i-1];
      assign prev_vld   = cell_vld[i-1];
      assign prev_key   = cell_key[i-1];
      assign prev_mag   = cell_mag[i-1];
      assign prev_id    = cell_id[i-1];
    end

    if (i == MAX_SELECT - 1) begin : g_tail
      assign next_vld = 1'b0;
      assign next_key = cell_key[i];
      assign next_mag = cell_mag[i];
      assign next_id  = cell_id[i];
    end else begin : g_link
      assign next_vld = cell_vld[i+1];
      assign next_key = cell_key[i+1];
      assign next_mag = cell_mag[i+1];
      assign next_id  = cell_id[i+1];
    end

    topk_cell #(
      .KEY_BITS  (KEY_BITS),
      .INDEX_BITS(INDEX_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .en        (cell_en[i]),
      .in_key    (in_ch.key),
      .in_mag    (in_mag),
      .in_id     (in_ch.item_index),
      .prev_ahead(prev_ahead),
      .prev_vld  (prev_vld),
      .prev_key  (prev_key),
      .prev_mag  (prev_mag),
      .prev_id   (prev_id),
      .next_vld  (next_vld),
      .next_key  (next_key),
      .next_mag  (next_mag),
      .next_id   (next_id),
      .vld       (cell_vld[i]),
      .ahead     (cell_ahead[i]),
      .key       (cell_key[i]),
      .mag       (cell_mag[i]),
      .id        (cell_id[i])
    );
  end

  // The kept entries always form an unbroken run from the head.
  a_vld_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    ((cell_vld & (cell_vld + {{MAX_SELECT{1'b0}}, 1'b1})) == '0))
    else $error("kept entries are not contiguous from the head");

  // The item that closes a set leaves at least one entry to emit.
  a_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.set_end) |=> out_ch.valid)
    else $error("set end produced no result");

  // Taking the final result empties the list.
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_ch.out_last) |=> (cell_vld == '0))
    else $error("list not cleared after the final result");

  // Results appear only during the drain phase.
  a_out_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (state_r == ST_DRAIN))
    else $error("result shown outside the drain phase");

endmodule
